FILE: rtl/sdb_pkg.sv
// Shared types and constants for the stereo downmix / biquad core.
// No dependencies; every other file in rtl/ imports this package.
package sdb_pkg;

  // Field and datapath widths
  localparam int SMP_W    = 16;   // audio samples, results
  localparam int CF_W     = 16;   // Q2.14 coefficients, Q4.12 gain
  localparam int H_W      = 40;   // Q24.16 mix, filter values, history
  localparam int ACC_W    = 58;   // accumulator, holds b*v - a*y
  localparam int HALF_W   = 20;   // operand slice fed to the multiplier
  localparam int MUL_W    = HALF_W + 1;
  localparam int PROD_W   = MUL_W + CF_W;
  localparam int RND_W    = 45;   // Q30 -> Q16 rounded value
  localparam int SUM_W    = 46;   // rounded value plus history
  localparam int NUM_SLOTS = 8;   // sample slots in one frame
  localparam int CHAN_W   = 3;
  localparam int HIST_DEPTH = 8;
  localparam int HIST_IDX_W = 3;
  localparam int CLIP_W   = 32;

  // Configuration port
  localparam int APB_AW = 6;
  localparam int APB_DW = 64;
  localparam int REG_IDX_LSB = 3;
  localparam int MG_W   = 22;
  localparam int FW3_W  = 32;
  localparam logic [MG_W-1:0] MG_RESET = 22'h011000;
  localparam int FILT_W = 2 * APB_DW + FW3_W;

  typedef enum logic [2:0] {
    REG_MIX_L_LO,
    REG_MIX_L_HI,
    REG_MIX_R_LO,
    REG_MIX_R_HI,
    REG_FILT_FIRST,
    REG_FILT_SECOND,
    REG_FILT_THIRD,
    REG_MODE_GAIN
  } reg_idx_e;

  // Filter modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_SET_B = 2'd2;

  // Halfword offsets inside the packed filter words
  localparam logic [3:0] FSET_A_BASE = 4'd0;
  localparam logic [3:0] FSET_B_BASE = 4'd5;
  localparam logic [3:0] CF_B0 = 4'd0;
  localparam logic [3:0] CF_B1 = 4'd1;
  localparam logic [3:0] CF_B2 = 4'd2;
  localparam logic [3:0] CF_A1 = 4'd3;
  localparam logic [3:0] CF_A2 = 4'd4;

  // Output scaling
  localparam int GAIN_FRAC = 28;
  localparam int BQ_FRAC   = 14;
  localparam logic signed [ACC_W-1:0] GAIN_POS_LIM = ACC_W'(64'sd32767 <<< GAIN_FRAC);
  localparam logic signed [ACC_W-1:0] GAIN_NEG_LIM = ACC_W'(-(64'sd32768 <<< GAIN_FRAC));

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_0;
    logic signed [SMP_W-1:0] sample_1;
    logic signed [SMP_W-1:0] sample_2;
    logic signed [SMP_W-1:0] sample_3;
    logic signed [SMP_W-1:0] sample_4;
    logic signed [SMP_W-1:0] sample_5;
    logic signed [SMP_W-1:0] sample_6;
    logic signed [SMP_W-1:0] sample_7;
    logic                    block_end;
  } in_req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic [CLIP_W-1:0]       clip_total;
    logic                    block_end_out;
  } out_res_t;

  typedef struct packed {
    logic [2*APB_DW-1:0] mix_l;   // {high, low}
    logic [2*APB_DW-1:0] mix_r;
    logic [FILT_W-1:0]   filt;    // {third, second, first}
    logic [CF_W-1:0]     gain;
    logic [3:0]          nch;
    logic [1:0]          mode;
  } cfg_t;

  typedef enum logic [1:0] {
    SEL_SGN,    // low slice, signed (samples)
    SEL_LO,     // low slice, unsigned
    SEL_HI      // high slice, signed, weight 2^20
  } mac_sel_e;

  typedef enum logic [1:0] {
    OPND_SAMPLE,
    OPND_V,
    OPND_Y
  } opnd_e;

  typedef enum logic [2:0] {
    COEF_MIX,
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2,
    COEF_GAIN
  } coef_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MIX_END,
    ST_BQ,
    ST_BQ_FIN,
    ST_GAIN,
    ST_GAIN_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PART_Y,
    PART_H0,
    PART_H1
  } part_e;

  typedef struct packed {
    logic     en;
    logic     clr;
    logic     sub;
    mac_sel_e sel;
  } mac_ctl_t;

  typedef struct packed {
    logic              in_ready;
    logic              latch;
    logic              rotate;
    mac_ctl_t          mac;
    opnd_e             opnd;
    coef_e             coef;
    logic [CHAN_W-1:0] chan;
    logic              side;
    logic              stage;
    logic              ld_mix;
    logic              ld_y;
    logic              wr_h0;
    logic              wr_h1;
    logic              ld_gain;
    logic              ld_out;
  } sdb_ctl_t;

endpackage

FILE: rtl/sdb_regs.sv
// APB-style configuration registers of the downmix core.
// Depends on sdb_pkg.
module sdb_regs import sdb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [APB_DW-1:0] mll_q, mlh_q, mrl_q, mrh_q, fw1_q, fw2_q;
  logic [FW3_W-1:0]  fw3_q;
  logic [MG_W-1:0]   mg_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:REG_IDX_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mll_q <= '0;
      mlh_q <= '0;
      mrl_q <= '0;
      mrh_q <= '0;
      fw1_q <= '0;
      fw2_q <= '0;
      fw3_q <= '0;
      mg_q  <= MG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_MIX_L_LO:    mll_q <= pwdata;
        REG_MIX_L_HI:    mlh_q <= pwdata;
        REG_MIX_R_LO:    mrl_q <= pwdata;
        REG_MIX_R_HI:    mrh_q <= pwdata;
        REG_FILT_FIRST:  fw1_q <= pwdata;
        REG_FILT_SECOND: fw2_q <= pwdata;
        REG_FILT_THIRD:  fw3_q <= pwdata[FW3_W-1:0];
        REG_MODE_GAIN:   mg_q  <= pwdata[MG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIX_L_LO:    prdata = mll_q;
      REG_MIX_L_HI:    prdata = mlh_q;
      REG_MIX_R_LO:    prdata = mrl_q;
      REG_MIX_R_HI:    prdata = mrh_q;
      REG_FILT_FIRST:  prdata = fw1_q;
      REG_FILT_SECOND: prdata = fw2_q;
      REG_FILT_THIRD:  prdata = APB_DW'(fw3_q);
      REG_MODE_GAIN:   prdata = APB_DW'(mg_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.mix_l = {mlh_q, mll_q};
  assign cfg_o.mix_r = {mrh_q, mrl_q};
  assign cfg_o.filt  = {fw3_q, fw2_q, fw1_q};
  assign cfg_o.gain  = mg_q[15:0];
  assign cfg_o.nch   = mg_q[19:16];
  assign cfg_o.mode  = mg_q[21:20];

endmodule

FILE: rtl/sdb_mac.sv
// Shared multiply-accumulate unit: 21x16 signed product into a 58-bit sum.
// A 40-bit operand is taken in two slices. Depends on sdb_pkg.
module sdb_mac import sdb_pkg::*; (
  input  logic                    clk_i,
  input  mac_ctl_t                ctl_i,
  input  logic signed [H_W-1:0]   opnd_i,
  input  logic signed [CF_W-1:0]  coef_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  term, base, acc_d, acc_q;

  always_comb begin
    case (ctl_i.sel)
      SEL_SGN: mul_a = $signed({opnd_i[HALF_W-1], opnd_i[HALF_W-1:0]});
      SEL_LO:  mul_a = $signed({1'b0, opnd_i[HALF_W-1:0]});
      SEL_HI:  mul_a = $signed({opnd_i[H_W-1], opnd_i[H_W-1:HALF_W]});
      default: mul_a = '0;
    endcase
  end

  assign prod = mul_a * coef_i;

  always_comb begin
    term  = (ctl_i.sel == SEL_HI) ? (ACC_W'(prod) <<< HALF_W) : ACC_W'(prod);
    base  = ctl_i.clr ? '0 : acc_q;
    acc_d = ctl_i.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/sdb_ctrl.sv
// Sequencer that steps the shared MAC through mix, biquad and gain work.
// Depends on sdb_pkg.
module sdb_ctrl import sdb_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       slot_free_i,
  input  logic [3:0] nch_i,
  input  logic [1:0] mode_i,
  output sdb_ctl_t   ctl_o
);

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CHANNELS - 1);

  state_e           state_q, state_d;
  part_e            part_q, part_d;
  logic             side_q, side_d, stage_q, stage_d;
  logic [1:0]       step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]       nch_eff;
  logic             bq_last;

  // zero channels acts as one, too many acts as the maximum
  always_comb begin
    if (nch_i == 4'd0) begin
      nch_eff = 4'd1;
    end else if (nch_i > 4'(MAX_CHANNELS)) begin
      nch_eff = 4'(MAX_CHANNELS);
    end else begin
      nch_eff = nch_i;
    end
  end

  assign bq_last = (part_q == PART_Y) ? (step_q == 2'd1) : (step_q == 2'd3);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MIX;
      ST_MIX:      if (cnt_q == CNT_LAST) state_d = ST_MIX_END;
      ST_MIX_END:  state_d = (mode_i != MODE_OFF) ? ST_BQ : ST_GAIN;
      ST_BQ:       if (bq_last) state_d = ST_BQ_FIN;
      ST_BQ_FIN:   state_d = (part_q == PART_H1 && stage_q) ? ST_GAIN : ST_BQ;
      ST_GAIN:     if (step_q == 2'd1) state_d = ST_GAIN_FIN;
      ST_GAIN_FIN: state_d = side_q ? ST_OUT : ST_MIX;
      ST_OUT:      if (slot_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    side_d  = side_q;
    stage_d = stage_q;
    part_d  = part_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        side_d = 1'b0;
        cnt_d  = '0;
      end
      ST_MIX:     cnt_d = cnt_q + CNT_W'(1);
      ST_MIX_END: begin
        stage_d = 1'b0;
        part_d  = PART_Y;
        step_d  = 2'd0;
      end
      ST_BQ:      step_d = step_q + 2'd1;
      ST_BQ_FIN: begin
        step_d = 2'd0;
        case (part_q)
          PART_Y:  part_d = PART_H0;
          PART_H0: part_d = PART_H1;
          default: begin
            part_d  = PART_Y;
            stage_d = 1'b1;
          end
        endcase
      end
      ST_GAIN:    step_d = step_q + 2'd1;
      ST_GAIN_FIN: begin
        side_d = 1'b1;
        cnt_d  = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl_o         = '0;
    ctl_o.side    = side_q;
    ctl_o.stage   = stage_q;
    ctl_o.chan    = CHAN_W'(cnt_q);
    ctl_o.opnd    = OPND_V;
    ctl_o.coef    = COEF_MIX;
    ctl_o.mac.sel = step_q[0] ? SEL_HI : SEL_LO;
    case (state_q)
      ST_IDLE: begin
        ctl_o.in_ready = 1'b1;
        ctl_o.latch    = in_valid_i;
      end
      ST_MIX: begin
        ctl_o.rotate  = 1'b1;
        ctl_o.mac.en  = (4'(cnt_q) < nch_eff);
        ctl_o.mac.clr = (cnt_q == '0);
        ctl_o.mac.sel = SEL_SGN;
        ctl_o.opnd    = OPND_SAMPLE;
      end
      ST_MIX_END: ctl_o.ld_mix = 1'b1;
      ST_BQ: begin
        // v terms first (lo, hi), then, for h0 and h1, y terms subtracted (lo, hi)
        ctl_o.mac.en  = 1'b1;
        ctl_o.mac.clr = (step_q == 2'd0);
        ctl_o.mac.sub = step_q[1];
        ctl_o.opnd    = step_q[1] ? OPND_Y : OPND_V;
        case (part_q)
          PART_Y:  ctl_o.coef = COEF_B0;
          PART_H0: ctl_o.coef = step_q[1] ? COEF_A1 : COEF_B1;
          default: ctl_o.coef = step_q[1] ? COEF_A2 : COEF_B2;
        endcase
      end
      ST_BQ_FIN: begin
        case (part_q)
          PART_Y:  ctl_o.ld_y  = 1'b1;
          PART_H0: ctl_o.wr_h0 = 1'b1;
          default: ctl_o.wr_h1 = 1'b1;
        endcase
      end
      ST_GAIN: begin
        ctl_o.mac.en  = 1'b1;
        ctl_o.mac.clr = (step_q == 2'd0);
        ctl_o.coef    = COEF_GAIN;
      end
      ST_GAIN_FIN: ctl_o.ld_gain = 1'b1;
      ST_OUT:      ctl_o.ld_out  = slot_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      part_q  <= PART_Y;
      side_q  <= 1'b0;
      stage_q <= 1'b0;
      step_q  <= 2'd0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      part_q  <= part_d;
      side_q  <= side_d;
      stage_q <= stage_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: rtl/stereo_downmix_biquad_core.sv
// Top level of the stereo downmix core: datapath, history and output register.
// Depends on sdb_pkg, sdb_regs, sdb_mac and sdb_ctrl.
//
//  port group       dir  handshake            payload
//  in_*             in   in_valid_i/in_ready_o  in_req_t (8 samples, block_end)
//  out_*            out  out_valid_o/out_ready_i out_res_t (left, right, clips, end)
//  APB (psel...)    in   psel&penable&pwrite    64-bit registers at 8*i
//
// Every product goes through the single 21x16 MAC, and a 40-bit operand needs
// two passes. in_ready_o is high only while idle. The next frame is accepted
// and computed while the previous result still waits in the output register;
// a finished result holds in its last state, with in_ready_o low, until that
// register frees. Reset clears the history, the clip count and all control.
module stereo_downmix_biquad_core import sdb_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_req_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_res_t          out_res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  sdb_ctl_t ctl;

  logic signed [SMP_W-1:0] in_smp [NUM_SLOTS];
  logic signed [SMP_W-1:0] smp_q  [MAX_CHANNELS];   // ring, slot 0 feeds the MAC
  logic                    be_q;

  logic signed [H_W-1:0]   v_q, y_q;
  logic signed [H_W-1:0]   hist_q [HIST_DEPTH];
  logic signed [SMP_W-1:0] left_q, right_q;
  logic [CLIP_W-1:0]       clip_q;

  logic                    out_valid_q;
  out_res_t                out_q;

  logic signed [H_W-1:0]   mac_opnd;
  logic signed [CF_W-1:0]  mac_coef;
  logic signed [ACC_W-1:0] acc;

  // Q30 -> Q16, half away from zero
  function automatic logic signed [RND_W-1:0] rnd14(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] r;
    mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    r   = (mag + (ACC_W'(1) << (BQ_FRAC - 1))) >> BQ_FRAC;
    return x[ACC_W-1] ? -$signed(RND_W'(r)) : $signed(RND_W'(r));
  endfunction

  function automatic logic signed [H_W-1:0] sat40(input logic signed [SUM_W-1:0] s);
    logic fits;
    fits = (s[SUM_W-1:H_W-1] == '0) || (s[SUM_W-1:H_W-1] == '1);
    if (fits) return s[H_W-1:0];
    return s[SUM_W-1] ? {1'b1, {(H_W-1){1'b0}}} : {1'b0, {(H_W-1){1'b1}}};
  endfunction

  sdb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdb_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .slot_free_i (!out_valid_q || out_ready_i),
    .nch_i       (cfg.nch),
    .mode_i      (cfg.mode),
    .ctl_o       (ctl)
  );

  sdb_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (ctl.mac),
    .opnd_i (mac_opnd),
    .coef_i (mac_coef),
    .acc_o  (acc)
  );

  assign in_ready_o = ctl.in_ready;

  assign in_smp[0] = in_req_i.sample_0;
  assign in_smp[1] = in_req_i.sample_1;
  assign in_smp[2] = in_req_i.sample_2;
  assign in_smp[3] = in_req_i.sample_3;
  assign in_smp[4] = in_req_i.sample_4;
  assign in_smp[5] = in_req_i.sample_5;
  assign in_smp[6] = in_req_i.sample_6;
  assign in_smp[7] = in_req_i.sample_7;

  // Sample ring: the mix rotates it once per channel slot, so after the
  // full pass it is back in place for the other side.
  always_ff @(posedge clk_i) begin
    if (ctl.latch) begin
      for (int i = 0; i < MAX_CHANNELS; i++) smp_q[i] <= in_smp[i];
      be_q <= in_req_i.block_end;
    end else if (ctl.rotate) begin
      for (int i = 0; i < MAX_CHANNELS; i++) smp_q[i] <= smp_q[(i + 1) % MAX_CHANNELS];
    end
  end

  // MAC operand and coefficient selection
  logic [3:0] fbase, fidx;
  logic [2*APB_DW-1:0] mix_row;

  always_comb begin
    case (ctl.opnd)
      OPND_SAMPLE: mac_opnd = H_W'(smp_q[0]);
      OPND_V:      mac_opnd = v_q;
      OPND_Y:      mac_opnd = y_q;
      default:     mac_opnd = v_q;
    endcase
  end

  always_comb begin
    fbase   = (cfg.mode == MODE_SET_B) ? FSET_B_BASE : FSET_A_BASE;
    mix_row = ctl.side ? cfg.mix_r : cfg.mix_l;
    case (ctl.coef)
      COEF_B0: fidx = fbase + CF_B0;
      COEF_B1: fidx = fbase + CF_B1;
      COEF_B2: fidx = fbase + CF_B2;
      COEF_A1: fidx = fbase + CF_A1;
      COEF_A2: fidx = fbase + CF_A2;
      default: fidx = fbase;
    endcase
    case (ctl.coef)
      COEF_MIX:  mac_coef = $signed(mix_row[ctl.chan*CF_W +: CF_W]);
      COEF_GAIN: mac_coef = $signed(cfg.gain);
      default:   mac_coef = $signed(cfg.filt[fidx*CF_W +: CF_W]);
    endcase
  end

  // Biquad write-back. The history read uses h0 for y and h1 for the new h0.
  logic [HIST_IDX_W-1:0]   h_rd_idx;
  logic signed [H_W-1:0]   h_add, bq_val;
  logic signed [RND_W-1:0] rnd;

  always_comb begin
    h_rd_idx = {ctl.side, ctl.stage, ctl.wr_h0};
    h_add    = ctl.wr_h1 ? '0 : hist_q[h_rd_idx];
    rnd      = rnd14(acc);
    bq_val   = sat40(SUM_W'(rnd) + SUM_W'(h_add));
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_mix) begin
      v_q <= H_W'(acc <<< 2);   // Q14 mix to Q16
    end else if (ctl.wr_h1) begin
      v_q <= y_q;               // stage output feeds the next stage / gain
    end
    if (ctl.ld_y) y_q <= bq_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
    end else if (ctl.wr_h0) begin
      hist_q[{ctl.side, ctl.stage, 1'b0}] <= bq_val;
    end else if (ctl.wr_h1) begin
      hist_q[{ctl.side, ctl.stage, 1'b1}] <= bq_val;
    end
  end

  // Gain stage: Q28 product, clip outside 16 bits, else round half away
  logic                    pos_clip, neg_clip;
  logic [ACC_W-1:0]        g_mag, g_r;
  logic signed [SMP_W-1:0] g_res;

  always_comb begin
    pos_clip = (acc > GAIN_POS_LIM);
    neg_clip = (acc < GAIN_NEG_LIM);
    g_mag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    g_r      = (g_mag + (ACC_W'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
    if (pos_clip) begin
      g_res = 16'sh7FFF;
    end else if (neg_clip) begin
      g_res = 16'sh8000;
    end else begin
      g_res = acc[ACC_W-1] ? -$signed(SMP_W'(g_r)) : $signed(SMP_W'(g_r));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_gain) begin
      if (ctl.side) right_q <= g_res;
      else          left_q  <= g_res;
    end
  end

  // clip count saturates at all ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= '0;
    end else if (ctl.ld_gain && (pos_clip || neg_clip) && (clip_q != '1)) begin
      clip_q <= clip_q + CLIP_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_out) begin
      out_q.left_sample   <= left_q;
      out_q.right_sample  <= right_q;
      out_q.clip_total    <= clip_q;
      out_q.block_end_out <= be_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

FILE: tb/sv/sdb_tb_pkg.sv
// Scoreboard for the stereo downmix / biquad core testbench: a bit-exact
// predictor of mix, filter cascade, gain and clip count, plus the result check.
// Depends on sdb_pkg for the request/result structs and register indexes.
package sdb_tb_pkg;
  import sdb_pkg::*;

  localparam int CORE_MAX_CH = 8;
  localparam logic [1:0] MODE_SET_A = 2'd1;
  localparam logic [1:0] MODE_SET_A_ALT = 2'd3;
  localparam longint HIST_MAX = (64'sd1 <<< 39) - 1;
  localparam longint HIST_MIN = -(64'sd1 <<< 39);
  localparam longint OUT_POS_LIM = 64'sd32767 <<< 28;
  localparam longint OUT_NEG_LIM = -(64'sd32768 <<< 28);
  localparam longint HALF_Q28 = 64'sd134217728;
  localparam int REPORT_MAX = 10;

  class stereo_scoreboard;
    logic [63:0] regs [8];
    longint      hist [8];
    logic [31:0] clips;
    out_res_t    pending_stereo [$];
    int          mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[REG_MODE_GAIN] = 64'(MG_RESET);
      foreach (hist[i]) hist[i] = 0;
      clips = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [63:0] value);
      case (idx)
        REG_FILT_THIRD: regs[idx] = {32'd0, value[31:0]};
        REG_MODE_GAIN:  regs[idx] = {42'd0, value[21:0]};
        default:        regs[idx] = value;
      endcase
    endfunction

    static function longint half(logic [63:0] word, int k);
      logic signed [15:0] h;
      h = word[16*k +: 16];
      return longint'(h);
    endfunction

    static function longint sat40(longint x);
      if (x > HIST_MAX) return HIST_MAX;
      if (x < HIST_MIN) return HIST_MIN;
      return x;
    endfunction

    // Q30 -> Q16, half away from zero
    static function longint round_q30(longint x);
      if (x >= 0) return (x + 64'sd8192) >>> 14;
      return -((-x + 64'sd8192) >>> 14);
    endfunction

    function void bump_clips();
      if (clips != '1) clips++;
    endfunction

    // Stereo result of one frame; advances history and clip count.
    function out_res_t downmix_frame(in_req_t req);
      longint      smp [8];
      longint      cf [5];
      longint      v, w, y, gain, res;
      logic [63:0] lo, hi;
      logic [1:0]  mode;
      int          nch, base;
      out_res_t    r;
      smp[0] = longint'(req.sample_0);
      smp[1] = longint'(req.sample_1);
      smp[2] = longint'(req.sample_2);
      smp[3] = longint'(req.sample_3);
      smp[4] = longint'(req.sample_4);
      smp[5] = longint'(req.sample_5);
      smp[6] = longint'(req.sample_6);
      smp[7] = longint'(req.sample_7);
      nch = int'(regs[REG_MODE_GAIN][19:16]);
      if (nch < 1) nch = 1;
      if (nch > CORE_MAX_CH) nch = CORE_MAX_CH;
      mode = regs[REG_MODE_GAIN][21:20];
      gain = half(regs[REG_MODE_GAIN], 0);
      if (mode == MODE_SET_B) begin
        cf[0] = half(regs[REG_FILT_SECOND], 1);
        cf[1] = half(regs[REG_FILT_SECOND], 2);
        cf[2] = half(regs[REG_FILT_SECOND], 3);
        cf[3] = half(regs[REG_FILT_THIRD], 0);
        cf[4] = half(regs[REG_FILT_THIRD], 1);
      end else begin
        cf[0] = half(regs[REG_FILT_FIRST], 0);
        cf[1] = half(regs[REG_FILT_FIRST], 1);
        cf[2] = half(regs[REG_FILT_FIRST], 2);
        cf[3] = half(regs[REG_FILT_FIRST], 3);
        cf[4] = half(regs[REG_FILT_SECOND], 0);
      end
      r = '0;
      for (int side = 0; side < 2; side++) begin
        lo = regs[side != 0 ? REG_MIX_R_LO : REG_MIX_L_LO];
        hi = regs[side != 0 ? REG_MIX_R_HI : REG_MIX_L_HI];
        v = 0;
        for (int j = 0; j < nch; j++) v += smp[j] * half(j < 4 ? lo : hi, j % 4);
        v = v * 4;
        if (mode != MODE_OFF) begin
          for (int stage = 0; stage < 2; stage++) begin
            base = side * 4 + stage * 2;
            y = sat40(round_q30(cf[0] * v) + hist[base]);
            hist[base] = sat40(round_q30(cf[1] * v - cf[3] * y) + hist[base + 1]);
            hist[base + 1] = sat40(round_q30(cf[2] * v - cf[4] * y));
            v = y;
          end
        end
        w = v * gain;
        if (w > OUT_POS_LIM) begin
          res = 32767;
          bump_clips();
        end else if (w < OUT_NEG_LIM) begin
          res = -32768;
          bump_clips();
        end else if (w >= 0) begin
          res = (w + HALF_Q28) >>> 28;
        end else begin
          res = -((-w + HALF_Q28) >>> 28);
        end
        if (side == 0) r.left_sample = res[15:0];
        else r.right_sample = res[15:0];
      end
      r.clip_total = clips;
      r.block_end_out = req.block_end;
      return r;
    endfunction

    function void note_frame(in_req_t req);
      pending_stereo.push_back(downmix_frame(req));
    endfunction

    function void report(string what, longint want_v, longint got_v);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (pending_stereo.size() == 0) begin
        report("result with no frame pending, left_sample", 0, longint'(got.left_sample));
        return;
      end
      want = pending_stereo.pop_front();
      if (got.left_sample !== want.left_sample)
        report("left_sample", longint'(want.left_sample), longint'(got.left_sample));
      if (got.right_sample !== want.right_sample)
        report("right_sample", longint'(want.right_sample), longint'(got.right_sample));
      if (got.clip_total !== want.clip_total)
        report("clip_total", longint'(want.clip_total), longint'(got.clip_total));
      if (got.block_end_out !== want.block_end_out)
        report("block_end_out", longint'(want.block_end_out), longint'(got.block_end_out));
    endfunction

    function int leftover();
      return pending_stereo.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_stereo_downmix_biquad_core.sv
// Top-level testbench for stereo_downmix_biquad_core: directed and random
// frames under random idling, APB setup between phases, scoreboard checks.
// Depends on sdb_pkg, sdb_tb_pkg and the core RTL.
module tb_stereo_downmix_biquad_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sdb_pkg::*;
  import sdb_tb_pkg::*;

  localparam int RESET_CYCLES   = 3;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_FRAMES   = 185;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  in_req_t           in_req_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_res_t          out_res_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  stereo_scoreboard sb = new();

  int frames_in    = 0;   // requests accepted so far
  int quiet_cycles = 0;   // cycles since the last handshake of any kind
  int out_hold     = 0;   // remaining cycles of the current output stall
  bit steady       = 1'b0; // no idling on either side while set

  stereo_downmix_biquad_core #(
    .MAX_CHANNELS(CORE_MAX_CH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Random idling: mostly none, some short gaps, a few long ones.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output side: ready drops for random stretches. Driven on the falling edge.
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_ready_i <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) out_hold <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled on the rising edge. Requests feed the
  // predictor, results are checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sb.note_frame(in_req_i);
      frames_in++;
    end
    if (out_valid_o && out_ready_i) sb.check_result(out_res_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered just after a falling edge and returns just
  // after one, without having assigned anything at that last edge.
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, access cycle, then an idle cycle.
  task automatic apb_write(reg_idx_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << REG_IDX_LSB;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    sb.write_reg(idx, value);   // landed at the edge just passed
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Present one request after an optional gap and hold it until accepted.
  task automatic send_frame(in_req_t req, int gap);
    int seen;
    seen = frames_in;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(negedge clk_i); while (frames_in == seen);
  endtask

  // Quiesce before touching registers: all results in, then the frame latency.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.leftover() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_req_t uniform(logic [15:0] s, logic be);
    return in_req_t'({{8{s}}, be});
  endfunction

  function automatic in_req_t lone(logic [15:0] s0, logic be);
    return in_req_t'({s0, {7{16'h0000}}, be});
  endfunction

  function automatic logic [63:0] mg_word(logic [1:0] mode, logic [3:0] nch,
                                          logic [15:0] gain);
    return {42'd0, mode, nch, gain};
  endfunction

  // Coefficient biased toward the Q2.14 extremes and unity.
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'h4000;
      4:       return 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Small signed coefficient in [-span, span].
  function automatic logic [15:0] gentle(int span);
    return 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  function automatic in_req_t random_frame();
    logic [15:0] s [8];
    logic [15:0] common;
    int          style;
    style  = $urandom_range(0, 9);
    common = 16'($urandom);
    foreach (s[i]) begin
      case (style)
        6, 7:    s[i] = gentle(64);
        8:       s[i] = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        9:       s[i] = common;
        default: s[i] = 16'($urandom);
      endcase
    end
    return in_req_t'({s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7],
                      1'($urandom_range(0, 7) == 0)});
  endfunction

  // New register set for one random phase. Phase 0 and 1 pin the extremes.
  task automatic setup_phase(int ph);
    logic [15:0] mix [16];
    logic [15:0] fa [5];
    logic [15:0] fb [5];
    logic [15:0] gain;
    logic [3:0]  nch;
    logic [1:0]  mode;
    bit          tame;
    tame = ($urandom_range(0, 3) != 0);
    foreach (mix[i]) mix[i] = tame ? gentle(16'h2000) : pick_coef();
    // Well-behaved filters keep the history alive instead of pinning it
    // at the 40-bit rails: |a2| <= 0.25 and |a1| <= 0.5 stay stable.
    for (int k = 0; k < 3; k++) begin
      fa[k] = tame ? gentle(16'h3000) : pick_coef();
      fb[k] = tame ? gentle(16'h3000) : pick_coef();
    end
    fa[3] = tame ? gentle(16'h2000) : pick_coef();
    fb[3] = tame ? gentle(16'h2000) : pick_coef();
    fa[4] = tame ? gentle(16'h1000) : pick_coef();
    fb[4] = tame ? gentle(16'h1000) : pick_coef();
    case ($urandom_range(0, 4))
      0:       gain = 16'h1000;
      1:       gain = 16'h8000;
      2:       gain = 16'h7FFF;
      3:       gain = gentle(16'h2000);
      default: gain = 16'($urandom);
    endcase
    nch  = 4'($urandom_range(0, 15));
    mode = 2'($urandom_range(0, 3));
    if (ph == 0) begin
      foreach (mix[i]) mix[i] = 16'h7FFF;
      foreach (fa[i]) fa[i] = 16'h7FFF;
      foreach (fb[i]) fb[i] = 16'h7FFF;
      gain = 16'h7FFF;
      nch  = 4'd15;
      mode = MODE_SET_A_ALT;
    end else if (ph == 1) begin
      foreach (mix[i]) mix[i] = 16'h8000;
      foreach (fa[i]) fa[i] = 16'h8000;
      foreach (fb[i]) fb[i] = 16'h8000;
      gain = 16'h8000;
      nch  = 4'd0;
      mode = MODE_SET_B;
    end
    apb_write(REG_MIX_L_LO, {mix[3], mix[2], mix[1], mix[0]});
    apb_write(REG_MIX_L_HI, {mix[7], mix[6], mix[5], mix[4]});
    apb_write(REG_MIX_R_LO, {mix[11], mix[10], mix[9], mix[8]});
    apb_write(REG_MIX_R_HI, {mix[15], mix[14], mix[13], mix[12]});
    apb_write(REG_FILT_FIRST, {fa[3], fa[2], fa[1], fa[0]});
    apb_write(REG_FILT_SECOND, {fb[2], fb[1], fb[0], fa[4]});
    apb_write(REG_FILT_THIRD, {32'd0, fb[4], fb[3]});
    apb_write(REG_MODE_GAIN, mg_word(mode, nch, gain));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setup: unity gain, one channel, no filter, zero mix -> silence.
    send_frame(uniform(16'h7FFF, 1'b0), 0);
    send_frame(uniform(16'h8000, 1'b1), 0);
    settle();

    // Plain mix at half gain, all eight channels. Odd single samples land
    // exactly on a half and must round away from zero; full scale clips.
    apb_write(REG_MIX_L_LO, {4{16'h4000}});
    apb_write(REG_MIX_L_HI, {4{16'h7FFF}});
    apb_write(REG_MIX_R_LO, {4{16'h8000}});
    apb_write(REG_MIX_R_HI, {4{16'hC000}});
    apb_write(REG_MODE_GAIN, mg_word(MODE_OFF, 4'd8, 16'h0800));
    send_frame(uniform(16'h7FFF, 1'b0), 0);
    send_frame(uniform(16'h8000, 1'b0), 0);
    send_frame(lone(16'h0001, 1'b0), 0);
    send_frame(lone(16'hFFFF, 1'b0), 0);
    send_frame(lone(16'h0003, 1'b0), 0);
    send_frame(lone(16'hFFFD, 1'b0), 0);
    send_frame(uniform(16'h0000, 1'b1), 0);
    settle();

    // Channel count zero behaves as one; above the maximum as the maximum.
    apb_write(REG_MODE_GAIN, mg_word(MODE_OFF, 4'd0, 16'h7FFF));
    send_frame(uniform(16'h7FFF, 1'b0), 0);
    send_frame(uniform(16'h8000, 1'b0), 0);
    settle();
    apb_write(REG_MODE_GAIN, mg_word(MODE_OFF, 4'd15, 16'h8000));
    send_frame(uniform(16'h7FFF, 1'b0), 0);
    send_frame(random_frame(), 0);
    settle();

    // Filter set A runaway: feedback of two drives the history into the
    // 40-bit rails within a few frames.
    apb_write(REG_FILT_FIRST, {16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    apb_write(REG_FILT_SECOND, {16'hE000, 16'h8000, 16'h4000, 16'h8000});
    apb_write(REG_FILT_THIRD, {32'd0, 16'h1000, 16'hE000});
    apb_write(REG_MODE_GAIN, mg_word(MODE_SET_A, 4'd8, 16'h1000));
    for (int i = 0; i < 5; i++)
      send_frame(uniform(i % 2 == 0 ? 16'h7FFF : 16'h8000, 1'b0), 0);
    settle();
    // Mode three uses set A as well.
    apb_write(REG_MODE_GAIN, mg_word(MODE_SET_A_ALT, 4'd8, 16'h1000));
    send_frame(uniform(16'h8000, 1'b0), 0);
    send_frame(uniform(16'h7FFF, 1'b1), 0);
    settle();
    apb_write(REG_MODE_GAIN, mg_word(MODE_SET_B, 4'd4, 16'h1000));
    send_frame(uniform(16'h7FFF, 1'b0), 0);
    send_frame(uniform(16'h0000, 1'b0), 0);
    send_frame(random_frame(), 0);
    settle();

    // Random phases; every fourth one runs without idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      setup_phase(ph);
      steady = (ph % 4 == 2);
      for (int n = 0; n < PHASE_FRAMES; n++) send_frame(random_frame(), pick_gap());
      settle();
      steady = 1'b0;
    end

    if (sb.mismatches == 0 && sb.leftover() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
